FILE: hdl/abf_pkg.sv
// Shared types and codes for the async bit framer.
`timescale 1ns / 1ps

package abf_pkg;

   localparam int BYTE_W = 8;

   // operation codes carried in the request beat
   localparam logic OP_RX = 1'b0;
   localparam logic OP_TX = 1'b1;

   // received event kinds
   localparam logic [1:0] KIND_ZERO    = 2'd0;
   localparam logic [1:0] KIND_ONE     = 2'd1;
   localparam logic [1:0] KIND_CARRIER = 2'd2;
   localparam logic [1:0] KIND_OTHER   = 2'd3;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_CARRIER = 2'd1,
      PHASE_ACTIVE  = 2'd2
   } phase_type;

   typedef struct packed {
      logic              op;
      logic [1:0]        rx_kind;
      logic              tx_offer_valid;
      logic [BYTE_W-1:0] tx_offer_byte;
   } req_type;

   typedef struct packed {
      logic              rx_byte_valid;
      logic [BYTE_W-1:0] rx_byte;
      logic              tx_bit;
      logic              tx_offer_taken;
      logic              link_active;
      logic              kick_done;
   } rsp_type;

endpackage

FILE: hdl/abf_rx.sv
// Receive side: link bring-up and frame recovery over a sliding bit window.
`timescale 1ns / 1ps

module abf_rx #(
   parameter int DATA_BITS = 8,
   parameter int STOP_BITS = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      event_en,
   input  logic [1:0]                kind,
   output logic                      byte_valid,
   output logic [abf_pkg::BYTE_W-1:0] byte_out,
   output logic                      link_active,
   output logic                      link_active_next
);
   import abf_pkg::*;

   localparam int FRAME_BITS = 1 + DATA_BITS + STOP_BITS;
   localparam int CNT_W      = $clog2(FRAME_BITS);

   phase_type              phase_ff, phase_in;
   logic [FRAME_BITS-1:0]  win_ff, win_in, win_shift;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   bit_en;
   logic                   full;
   logic                   frame_ok;

   // next state of the carrier phase
   always_comb begin
      phase_in = phase_ff;
      if (event_en) begin
         case (phase_ff)
            PHASE_IDLE: begin
               if (kind == KIND_CARRIER) phase_in = PHASE_CARRIER;
            end
            PHASE_CARRIER: begin
               if (kind == KIND_CARRIER) phase_in = PHASE_CARRIER;
               else if (kind == KIND_ONE) phase_in = PHASE_ACTIVE;
            end
            PHASE_ACTIVE: phase_in = PHASE_ACTIVE;
            default: begin
               if (kind == KIND_CARRIER) phase_in = PHASE_CARRIER;
            end
         endcase
      end
   end

   // outputs of the phase machine
   assign link_active      = (phase_ff == PHASE_ACTIVE);
   assign link_active_next = (phase_in == PHASE_ACTIVE);

   // new bit enters at the top; the oldest sits at bit 0 once the window is full
   assign bit_en    = event_en && link_active && (kind == KIND_ZERO || kind == KIND_ONE);
   assign win_shift = {kind[0], win_ff[FRAME_BITS-1:1]};
   assign full      = (cnt_ff == CNT_W'(FRAME_BITS - 1));
   assign frame_ok  = !win_shift[0] && win_shift[1 + DATA_BITS];

   always_comb begin
      win_in     = win_ff;
      cnt_in     = cnt_ff;
      byte_valid = 1'b0;
      byte_out   = '0;
      if (bit_en) begin
         win_in = win_shift;
         if (!full) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end else if (frame_ok) begin
            // consume the whole frame, stop bits included
            cnt_in     = '0;
            byte_valid = 1'b1;
            byte_out   = BYTE_W'(win_shift[DATA_BITS:1]);
         end else begin
            // drop the oldest bit
            cnt_in = CNT_W'(FRAME_BITS - 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

FILE: hdl/abf_tx.sv
// Transmit side: kickstart and byte framing through a bit shift queue.
`timescale 1ns / 1ps

module abf_tx #(
   parameter int DATA_BITS = 8,
   parameter int STOP_BITS = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_en,
   input  logic                       link_active,
   input  logic                       offer_valid,
   input  logic [abf_pkg::BYTE_W-1:0] offer_byte,
   output logic                       tx_bit,
   output logic                       offer_taken,
   output logic                       kick_done_next
);
   import abf_pkg::*;

   localparam int QUEUE_BITS = DATA_BITS + STOP_BITS;
   localparam int CNT_W      = $clog2(QUEUE_BITS + 1);

   logic [QUEUE_BITS-1:0] sr_ff, sr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  kick_ff, kick_in;
   logic                  empty;

   assign empty          = (cnt_ff == '0);
   assign kick_done_next = kick_in;

   always_comb begin
      sr_in       = sr_ff;
      cnt_in      = cnt_ff;
      kick_in     = kick_ff;
      tx_bit      = 1'b1;
      offer_taken = 1'b0;
      if (req_en) begin
         if (!empty) begin
            // send the next queued bit
            tx_bit = sr_ff[0];
            sr_in  = sr_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
         end else if (kick_ff) begin
            if (offer_valid) begin
               tx_bit      = 1'b0;
               offer_taken = 1'b1;
               sr_in       = {{STOP_BITS{1'b1}}, offer_byte[DATA_BITS-1:0]};
               cnt_in      = CNT_W'(QUEUE_BITS);
            end
         end else if (link_active) begin
            // kickstart NUL frame
            tx_bit  = 1'b0;
            kick_in = 1'b1;
            sr_in   = {{STOP_BITS{1'b1}}, {DATA_BITS{1'b0}}};
            cnt_in  = CNT_W'(QUEUE_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         kick_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         kick_ff <= kick_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

endmodule

FILE: hdl/async_bit_framer_with_carrier_kick_core.sv
// Top level of the async start/stop bit framer and deframer with carrier kickstart.
`timescale 1ns / 1ps

// Bit-level start/stop framer for a modem link. Each request beat is either a
// received line event (op 0) or a request for the next transmit bit (op 1), and
// each produces exactly one response beat, in the cycle after it is accepted. A
// new request beat is taken every cycle while the response register is empty or
// being drained; the only thing that holds the input is a response that is
// stalled downstream, so the sustained rate is one beat per cycle, set by the
// single response register. Receive: events are ignored until a carrier-up
// event and then a one bit bring the link up; after that each data bit shifts
// into a window of 1 + DATA_BITS + STOP_BITS bits, and a full window with a
// zero start bit and a one first stop bit yields a byte (LSB first), otherwise
// the oldest bit is dropped. Transmit: the line idles at mark; the first
// request with an empty queue after link-up starts a NUL kickstart frame, later
// ones frame an offered byte. The start bit goes out on that same request and
// the data and stop bits follow on the next requests. link_active and
// kick_done in a response reflect state after that beat.

module async_bit_framer_with_carrier_kick_core #(
   parameter int DATA_BITS = 8,
   parameter int STOP_BITS = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  abf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output abf_pkg::rsp_type rsp_data
);
   import abf_pkg::*;

   logic    accept;
   logic    rx_en, tx_en;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic              rx_byte_valid;
   logic [BYTE_W-1:0] rx_byte;
   logic              link_active;
   logic              link_active_next;
   logic              tx_bit;
   logic              offer_taken;
   logic              kick_done_next;

   // Hold the input only while a finished response waits downstream.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rx_en     = accept && (req_data.op == OP_RX);
   assign tx_en     = accept && (req_data.op == OP_TX);

   abf_rx #(
      .DATA_BITS (DATA_BITS),
      .STOP_BITS (STOP_BITS)
   ) u_rx (
      .clock            (clock),
      .reset            (reset),
      .event_en         (rx_en),
      .kind             (req_data.rx_kind),
      .byte_valid       (rx_byte_valid),
      .byte_out         (rx_byte),
      .link_active      (link_active),
      .link_active_next (link_active_next)
   );

   // The transmit side sees the phase as it stands; a transmit beat never moves it.
   abf_tx #(
      .DATA_BITS (DATA_BITS),
      .STOP_BITS (STOP_BITS)
   ) u_tx (
      .clock          (clock),
      .reset          (reset),
      .req_en         (tx_en),
      .link_active    (link_active),
      .offer_valid    (req_data.tx_offer_valid),
      .offer_byte     (req_data.tx_offer_byte),
      .tx_bit         (tx_bit),
      .offer_taken    (offer_taken),
      .kick_done_next (kick_done_next)
   );

   // Assemble the response beat; receive events report mark and no take.
   always_comb begin
      rsp_data_in.rx_byte_valid  = rx_byte_valid;
      rsp_data_in.rx_byte        = rx_byte;
      rsp_data_in.tx_bit         = tx_en ? tx_bit : 1'b1;
      rsp_data_in.tx_offer_taken = tx_en && offer_taken;
      rsp_data_in.link_active    = link_active_next;
      rsp_data_in.kick_done      = kick_done_next;
   end

   // Keep the response valid while stalled; load a new one on every accept.
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the async bit framer core with carrier kickstart.
`timescale 1ns / 1ps

module tb;
   import abf_pkg::*;

   localparam int DATA_BITS     = 8;
   localparam int STOP_BITS     = 1;
   localparam int FRAME_BITS    = 1 + DATA_BITS + STOP_BITS;
   localparam int DIRECTED_ROWS = 21;
   localparam int RANDOM_ITEMS  = 1530;
   localparam int HOLD_START    = 600;     // receiver cycle at which the long hold-off begins
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 200000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // one row of the directed table; typed rows carry the response read off by hand
   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   // predictor state: link bring-up, kickstart flag, receive window, transmit line queue
   phase_type link_phase = PHASE_IDLE;
   logic      kick_sent  = 1'b0;
   bit        rx_window[$];
   bit        tx_line[$];

   rsp_type   expected_rsp[$];   // responses still owed by the core, oldest first
   bit        line_bits[$];      // serial bit stream waiting to go onto the receive side
   int        burst_left  = 0;
   int        fault_count = 0;
   int        cycle_count = 0;

   async_bit_framer_with_carrier_kick_core #(
      .DATA_BITS(DATA_BITS),
      .STOP_BITS(STOP_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Queue the data and stop bits of one frame; the start bit goes out on the request itself.
   function automatic void frame_tx_byte(logic [7:0] value);
      int i;
      for (i = 0; i < DATA_BITS; i++) tx_line.push_back(value[i]);
      repeat (STOP_BITS) tx_line.push_back(1'b1);
   endfunction

   // Advance the framer state by one request beat and return the response it owes.
   function automatic rsp_type framer_step(req_type beat);
      rsp_type    r;
      logic [7:0] acc;
      int         i;
      r        = '0;
      r.tx_bit = 1'b1;
      if (beat.op == OP_RX) begin
         if (link_phase != PHASE_ACTIVE) begin
            // bring-up: carrier first, then a mark bit; nothing enters the window yet
            if (beat.rx_kind == KIND_CARRIER) link_phase = PHASE_CARRIER;
            if (beat.rx_kind == KIND_ONE && link_phase == PHASE_CARRIER)
               link_phase = PHASE_ACTIVE;
         end else if (beat.rx_kind == KIND_ZERO || beat.rx_kind == KIND_ONE) begin
            rx_window.push_back(beat.rx_kind[0]);
            // consume a frame on a good start/stop pair, else drop the oldest bit
            while (rx_window.size() >= FRAME_BITS) begin
               if (rx_window[0] == 1'b0 && rx_window[1 + DATA_BITS] == 1'b1) begin
                  acc = '0;
                  for (i = 0; i < DATA_BITS; i++) acc[i] = rx_window[1 + i];
                  r.rx_byte_valid = 1'b1;
                  r.rx_byte       = acc;
                  repeat (FRAME_BITS) void'(rx_window.pop_front());
               end else begin
                  void'(rx_window.pop_front());
               end
            end
         end
      end else if (tx_line.size() == 0) begin
         if (kick_sent) begin
            if (beat.tx_offer_valid) begin
               frame_tx_byte(beat.tx_offer_byte);
               r.tx_offer_taken = 1'b1;
               r.tx_bit         = 1'b0;
            end
         end else if (link_phase == PHASE_ACTIVE) begin
            frame_tx_byte(8'h00);
            kick_sent = 1'b1;
            r.tx_bit  = 1'b0;
         end
      end else begin
         r.tx_bit = tx_line.pop_front();
      end
      r.link_active = (link_phase == PHASE_ACTIVE);
      r.kick_done   = kick_sent;
      return r;
   endfunction

   function automatic stim_row_type row(logic op, logic [1:0] kind, logic ov, logic [7:0] ob,
                                        bit typed, logic rv, logic [7:0] rb, logic tbit,
                                        logic taken, logic link, logic kick);
      stim_row_type s;
      s.beat.op             = op;
      s.beat.rx_kind        = kind;
      s.beat.tx_offer_valid = ov;
      s.beat.tx_offer_byte  = ob;
      s.typed               = typed;
      s.want.rx_byte_valid  = rv;
      s.want.rx_byte        = rb;
      s.want.tx_bit         = tbit;
      s.want.tx_offer_taken = taken;
      s.want.link_active    = link;
      s.want.kick_done      = kick;
      return s;
   endfunction

   // Offer one request beat in bursts with random gaps, hold it until accepted,
   // then record what the core owes for it.
   task automatic offer_beat(req_type beat, bit typed, rsp_type typed_rsp);
      rsp_type predicted;
      int      gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= beat;
      // wait for the edge where valid meets no stall
      do @(posedge clock); while (req_stall);
      predicted = framer_step(beat);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endfunction

   // Compare every accepted response beat against the oldest one still owed.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("response beat %h arrived with none owed", rsp_data);
            fault_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("rx_byte_valid", 8'(want.rx_byte_valid), 8'(rsp_data.rx_byte_valid));
            check_field("rx_byte", want.rx_byte, rsp_data.rx_byte);
            check_field("tx_bit", 8'(want.tx_bit), 8'(rsp_data.tx_bit));
            check_field("tx_offer_taken", 8'(want.tx_offer_taken),
                        8'(rsp_data.tx_offer_taken));
            check_field("link_active", 8'(want.link_active), 8'(rsp_data.link_active));
            check_field("kick_done", 8'(want.kick_done), 8'(rsp_data.kick_done));
         end
      end
   end

   // Receiver: stall in stretches of its own pattern, with one long hold-off so the
   // single response register fills and the core pushes back on its input.
   initial begin : rsp_side
      int  mode;
      int  stretch;
      int  i;
      int  tick;
      bit  held;
      tick = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && tick >= HOLD_START) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            tick += HOLD_CYCLES;
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(20, 80);
         for (i = 0; i < stretch; i++) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (i % 3 == 0);
            endcase
            @(posedge clock);
            tick++;
         end
      end
   end

   // Hard stop in case the core hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("async_bit_framer_with_carrier_kick_core: mismatch");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed[DIRECTED_ROWS];
      req_type      beat;
      logic [7:0]   data;
      int           k;
      int           pick;
      int           sent;

      // Directed table: bring-up, kickstart, one clean frame of all ones, busy offer.
      directed[0]  = row(OP_RX, KIND_ONE,     0, 8'h00, 1, 0, 8'h00, 1, 0, 0, 0);
      directed[1]  = row(OP_TX, KIND_ZERO,    1, 8'h00, 1, 0, 8'h00, 1, 0, 0, 0);
      directed[2]  = row(OP_RX, KIND_OTHER,   0, 8'h00, 1, 0, 8'h00, 1, 0, 0, 0);
      directed[3]  = row(OP_RX, KIND_ZERO,    1, 8'hFF, 1, 0, 8'h00, 1, 0, 0, 0);
      directed[4]  = row(OP_RX, KIND_CARRIER, 0, 8'h00, 1, 0, 8'h00, 1, 0, 0, 0);
      directed[5]  = row(OP_RX, KIND_ZERO,    0, 8'h00, 1, 0, 8'h00, 1, 0, 0, 0);
      directed[6]  = row(OP_RX, KIND_ONE,     0, 8'h00, 1, 0, 8'h00, 1, 0, 1, 0);
      directed[7]  = row(OP_RX, KIND_CARRIER, 1, 8'h5A, 1, 0, 8'h00, 1, 0, 1, 0);
      // first request after link-up starts the NUL kickstart, offer ignored
      directed[8]  = row(OP_TX, KIND_OTHER,   1, 8'hA5, 1, 0, 8'h00, 0, 0, 1, 1);
      directed[9]  = row(OP_RX, KIND_ZERO,    0, 8'h00, 0, 0, 8'h00, 0, 0, 0, 0);
      for (k = 10; k < 18; k++)
         directed[k] = row(OP_RX, KIND_ONE, k[0], 8'h3C, 0, 0, 8'h00, 0, 0, 0, 0);
      directed[18] = row(OP_RX, KIND_ONE,     0, 8'h00, 1, 1, 8'hFF, 1, 0, 1, 1);
      // kick frame still draining: offer refused, first NUL data bit goes out
      directed[19] = row(OP_TX, KIND_ONE,     1, 8'hFF, 1, 0, 8'h00, 0, 0, 1, 1);
      directed[20] = row(OP_RX, KIND_OTHER,   1, 8'hFF, 1, 0, 8'h00, 1, 0, 1, 1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_ROWS; k++)
         offer_beat(directed[k].beat, directed[k].typed, directed[k].want);

      // Random part: mostly well-formed serial frames on the receive side, interleaved
      // with transmit requests; some frames carry a bad stop bit, the rest is noise.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         beat.op             = OP_RX;
         beat.rx_kind        = 2'($urandom_range(0, 3));
         beat.tx_offer_valid = 1'($urandom_range(0, 1));
         beat.tx_offer_byte  = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 48) begin
            if (line_bits.size() == 0) begin
               repeat ($urandom_range(0, 2)) line_bits.push_back(1'b1);
               data = 8'($urandom_range(0, 255));
               line_bits.push_back(1'b0);
               for (k = 0; k < DATA_BITS; k++) line_bits.push_back(data[k]);
               line_bits.push_back($urandom_range(0, 9) != 0);
            end
            beat.rx_kind = line_bits.pop_front() ? KIND_ONE : KIND_ZERO;
         end else if (pick < 85) begin
            beat.op             = OP_TX;
            beat.tx_offer_valid = ($urandom_range(0, 3) != 0);
         end
         sent++;
         offer_beat(beat, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("async_bit_framer_with_carrier_kick_core: match");
      else
         $display("async_bit_framer_with_carrier_kick_core: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/abf_pkg.sv
hdl/abf_rx.sv
hdl/abf_tx.sv
hdl/async_bit_framer_with_carrier_kick_core.sv
tb/sv/tb.sv
